// ===== sv/gregorian_date_arithmetic_assert.svh =====
// Assertion helpers for gregorian_date_arithmetic.
// Both expect clk and arst_n in scope.
`ifndef GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_ASSERT_SVH

// Same-cycle implication.
`define GDA_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define GDA_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== sv/gda_pkg.sv =====
`default_nettype none

package gda_pkg;

	// Limits
	localparam int YEAR_MAX      = 9999;
	localparam int DAY_COUNT_MAX = 1048575;

	// Field widths
	localparam int OP_W    = 3;
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 21;
	localparam int DIFF_W  = 22;
	localparam int SER_W   = 23;

	// Stream widths
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_NORM = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_LESS = 3'd3,
		OP_DIFF = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SER_P,
		ST_SER_M,
		ST_SER_SUM,
		ST_COMBINE,
		ST_Q400,
		ST_Q100,
		ST_Q4,
		ST_Q1,
		ST_LEAP,
		ST_MON,
		ST_EMIT
	} state_t;

	typedef struct packed {
		state_t phase;
		logic   sel_b;
		logic   ready;
	} dp_cmd_t;

	typedef struct packed {
		logic less_op;
		logic diff_op;
		logic more;
		logic slot_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/gda_ctrl.sv =====
`default_nettype none

module gda_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  gda_pkg::dp_status_t status,
	output gda_pkg::dp_cmd_t    cmd
);
	import gda_pkg::*;

	state_t state_q, state_d;
	logic   sel_b_q, sel_b_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_b_q <= sel_b_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		sel_b_d = sel_b_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SER_P;
					sel_b_d = 1'b0;
				end
			end
			ST_SER_P:   state_d = ST_SER_M;
			ST_SER_M:   state_d = ST_SER_SUM;
			ST_SER_SUM: begin
				if (status.diff_op && !sel_b_q) begin
					sel_b_d = 1'b1;
					state_d = ST_SER_P;
				end else if (status.less_op) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_COMBINE;
				end
			end
			ST_COMBINE: state_d = status.diff_op ? ST_EMIT : ST_Q400;
			ST_Q400:    if (!status.more) state_d = ST_Q100;
			ST_Q100:    if (!status.more) state_d = ST_Q4;
			ST_Q4:      if (!status.more) state_d = ST_Q1;
			ST_Q1:      if (!status.more) state_d = ST_LEAP;
			ST_LEAP:    state_d = ST_MON;
			ST_MON:     if (!status.more) state_d = ST_EMIT;
			ST_EMIT:    if (status.slot_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.phase = state_q;
		cmd.sel_b = sel_b_q;
		cmd.ready = (state_q == ST_IDLE);
	end

endmodule

`default_nettype wire

// ===== sv/gda_dp.sv =====
`default_nettype none

module gda_dp #(
	parameter int YEAR_MAX      = gda_pkg::YEAR_MAX,
	parameter int DAY_COUNT_MAX = gda_pkg::DAY_COUNT_MAX
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  gda_pkg::dp_cmd_t                cmd,
	output gda_pkg::dp_status_t             status,
	input  logic                            s_tvalid,
	input  logic [gda_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [gda_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [gda_pkg::M_TDATA_W-1:0]   m_tdata
);
	import gda_pkg::*;

	localparam int ADJ_W = 13;
	localparam logic [SER_W-1:0] D400 = 23'd146097;
	localparam logic [SER_W-1:0] D100 = 23'd36524;
	localparam logic [SER_W-1:0] D4   = 23'd1461;
	localparam logic [SER_W-1:0] D1   = 23'd365;
	localparam logic [DIFF_W-1:0] DIFF_SAT = 22'd4194303;

	// x / 100 by reciprocal, exact for x below 43699
	function automatic logic [8:0] div100(input logic [14:0] x);
		logic [27:0] prod;
		begin
			prod   = 28'(x) * 28'd5243;
			div100 = prod[27:19];
		end
	endfunction

	function automatic logic leap(input logic [14:0] y);
		logic [8:0]  q;
		logic [14:0] back;
		begin
			q    = div100(y);
			back = 15'({6'd0, q} * 15'd100);
			leap = (y[1:0] == 2'd0) && ((back != y) || (q[1:0] == 2'd0));
		end
	endfunction

	function automatic logic [DAY_W-1:0] dim(input logic lp, input logic [MONTH_W-1:0] m);
		begin
			if (m == 4'd2)
				dim = lp ? 5'd29 : 5'd28;
			else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
				dim = 5'd30;
			else if (m >= 4'd1 && m <= 4'd12)
				dim = 5'd31;
			else
				dim = 5'd0;
		end
	endfunction

	// days before month m in a common year
	function automatic logic [8:0] cum(input logic [MONTH_W-1:0] m);
		begin
			case (m)
				4'd1:    cum = 9'd0;
				4'd2:    cum = 9'd31;
				4'd3:    cum = 9'd59;
				4'd4:    cum = 9'd90;
				4'd5:    cum = 9'd120;
				4'd6:    cum = 9'd151;
				4'd7:    cum = 9'd181;
				4'd8:    cum = 9'd212;
				4'd9:    cum = 9'd243;
				4'd10:   cum = 9'd273;
				4'd11:   cum = 9'd304;
				4'd12:   cum = 9'd334;
				default: cum = 9'd0;
			endcase
		end
	endfunction

	// input unpack
	logic [YEAR_W-1:0]  in_ya, in_yb;
	logic [MONTH_W-1:0] in_ma, in_mb;
	logic [DAY_W-1:0]   in_da, in_db;
	logic [COUNT_W-1:0] in_cnt;

	assign in_ya  = s_tdata[13:0];
	assign in_ma  = s_tdata[17:14];
	assign in_da  = s_tdata[22:18];
	assign in_cnt = s_tdata[43:23];
	assign in_yb  = s_tdata[57:44];
	assign in_mb  = s_tdata[61:58];
	assign in_db  = s_tdata[66:62];

	// validation
	logic lp_in_a, lp_in_b, ok_a, ok_b;
	logic signed [31:0]  cnt_ext;
	logic [COUNT_W-1:0]  cnt_sat;

	always_comb begin
		lp_in_a = leap({1'b0, in_ya});
		lp_in_b = leap({1'b0, in_yb});
		ok_a = (in_ya != '0) && (in_da != '0) && (in_da <= dim(lp_in_a, in_ma));
		ok_b = (in_yb != '0) && (in_db != '0) && (in_db <= dim(lp_in_b, in_mb));
		cnt_ext = {{(32-COUNT_W){in_cnt[COUNT_W-1]}}, in_cnt};
		if (cnt_ext > DAY_COUNT_MAX)
			cnt_sat = COUNT_W'(DAY_COUNT_MAX);
		else if (cnt_ext < -DAY_COUNT_MAX)
			cnt_sat = COUNT_W'(-DAY_COUNT_MAX);
		else
			cnt_sat = in_cnt;
	end

	// item registers
	logic [OP_W-1:0]    op_q;
	logic [YEAR_W-1:0]  ya_q, yb_q;
	logic [MONTH_W-1:0] ma_q, mb_q;
	logic [DAY_W-1:0]   da_q, db_q;
	logic               lpa_q, lpb_q;
	logic [COUNT_W-1:0] cnt_q;

	// serial unit
	logic [YEAR_W-1:0]  p_q;
	logic [8:0]         q100_q, q400_q;
	logic [SER_W-1:0]   t365_q;
	logic [ADJ_W-1:0]   adj_q;
	logic [SER_W-1:0]   sa_q, sb_q;

	// date walk
	logic               neg_q;
	logic [SER_W-1:0]   r_q;
	logic [14:0]        yacc_q;
	logic [MONTH_W-1:0] mm_q;
	logic [1:0]         c_q;
	logic               lp_q;
	logic [DIFF_W-1:0]  diff_q;
	logic               dsat_q;

	// result beat
	logic               m_valid_q;
	logic [YEAR_W-1:0]  oy_q;
	logic [MONTH_W-1:0] om_q;
	logic [DAY_W-1:0]   od_q;
	logic               oless_q;
	logic [DIFF_W-1:0]  odiff_q;
	logic               ooor_q;

	logic [YEAR_W-1:0]  sy, p_in;
	logic [MONTH_W-1:0] sm;
	logic [DAY_W-1:0]   sd;
	logic               slp;
	logic [ADJ_W-1:0]   adj_d;
	logic signed [SER_W:0] n_d, dd;
	logic [SER_W-1:0]   mag;
	logic               more;
	logic [SER_W-1:0]   sub_d;
	logic [14:0]        inc_d;
	logic               load, emit, date_ok, less_d;
	logic               walk_op, take_walk;

	assign load = cmd.ready && s_tvalid;
	assign emit = (cmd.phase == ST_EMIT) && status.slot_free;

	always_comb begin
		sy   = cmd.sel_b ? yb_q  : ya_q;
		sm   = cmd.sel_b ? mb_q  : ma_q;
		sd   = cmd.sel_b ? db_q  : da_q;
		slp  = cmd.sel_b ? lpb_q : lpa_q;
		p_in = sy - 14'd1;
		adj_d = {1'b0, p_q[13:2]} - {4'd0, q100_q} + {4'd0, q400_q} + {4'd0, cum(sm)}
			+ {{(ADJ_W-1){1'b0}}, (sm > 4'd2) && slp} + {8'd0, sd} - 13'd1;

		case (opcode_t'(op_q))
			OP_ADD:  n_d = $signed({1'b0, sa_q}) + {{(SER_W+1-COUNT_W){cnt_q[COUNT_W-1]}}, cnt_q};
			OP_SUB:  n_d = $signed({1'b0, sa_q}) - {{(SER_W+1-COUNT_W){cnt_q[COUNT_W-1]}}, cnt_q};
			default: n_d = $signed({1'b0, sa_q});
		endcase
		dd  = $signed({1'b0, sa_q}) - $signed({1'b0, sb_q});
		mag = dd[SER_W] ? SER_W'(-dd) : dd[SER_W-1:0];

		more  = 1'b0;
		sub_d = D1;
		inc_d = 15'd1;
		case (cmd.phase)
			ST_Q400: begin
				more  = !neg_q && (r_q >= D400);
				sub_d = D400;
				inc_d = 15'd400;
			end
			ST_Q100: begin
				more  = !neg_q && (c_q != 2'd3) && (r_q >= D100);
				sub_d = D100;
				inc_d = 15'd100;
			end
			ST_Q4: begin
				more  = !neg_q && (r_q >= D4);
				sub_d = D4;
				inc_d = 15'd4;
			end
			ST_Q1: begin
				more  = !neg_q && (c_q != 2'd3) && (r_q >= D1);
				sub_d = D1;
				inc_d = 15'd1;
			end
			ST_MON: begin
				sub_d = SER_W'(dim(lp_q, mm_q));
				more  = !neg_q && (mm_q != 4'd12) && (r_q >= sub_d);
				inc_d = 15'd0;
			end
			default: more = 1'b0;
		endcase

		date_ok = !neg_q && ({2'b00, yacc_q} <= 17'(YEAR_MAX));
		less_d  = {ya_q, ma_q, da_q} < {yb_q, mb_q, db_q};
		// normalize, add, subtract and the undefined opcodes take the walked date
		walk_op   = (op_q != OP_LESS) && (op_q != OP_DIFF);
		take_walk = walk_op && date_ok;
	end

	always_comb begin
		status.less_op   = (op_q == OP_LESS);
		status.diff_op   = (op_q == OP_DIFF);
		status.more      = more;
		status.slot_free = !m_valid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= s_tuser;
			ya_q  <= ok_a ? in_ya : 14'd1900;
			ma_q  <= ok_a ? in_ma : 4'd1;
			da_q  <= ok_a ? in_da : 5'd1;
			lpa_q <= ok_a && lp_in_a;
			yb_q  <= ok_b ? in_yb : 14'd1900;
			mb_q  <= ok_b ? in_mb : 4'd1;
			db_q  <= ok_b ? in_db : 5'd1;
			lpb_q <= ok_b && lp_in_b;
			cnt_q <= cnt_sat;
		end

		case (cmd.phase)
			ST_SER_P: begin
				p_q    <= p_in;
				q100_q <= div100({1'b0, p_in});
				q400_q <= div100({3'd0, p_in[13:2]});
			end
			ST_SER_M: begin
				t365_q <= {9'd0, p_q} * 23'd365;
				adj_q  <= adj_d;
			end
			ST_SER_SUM: begin
				if (cmd.sel_b) sb_q <= t365_q + SER_W'(adj_q);
				else           sa_q <= t365_q + SER_W'(adj_q);
			end
			ST_COMBINE: begin
				neg_q  <= n_d[SER_W];
				r_q    <= n_d[SER_W-1:0];
				yacc_q <= 15'd1;
				mm_q   <= 4'd1;
				c_q    <= 2'd0;
				dsat_q <= mag > SER_W'(DIFF_SAT);
				diff_q <= (mag > SER_W'(DIFF_SAT)) ? DIFF_SAT : mag[DIFF_W-1:0];
			end
			ST_Q400, ST_Q100, ST_Q4, ST_Q1, ST_MON: begin
				if (cmd.phase == ST_Q4) c_q <= 2'd0;
				if (more) begin
					r_q    <= r_q - sub_d;
					yacc_q <= yacc_q + inc_d;
					if (cmd.phase == ST_MON) mm_q <= mm_q + 4'd1;
					else if (cmd.phase == ST_Q100 || cmd.phase == ST_Q1) c_q <= c_q + 2'd1;
				end
			end
			ST_LEAP: lp_q <= leap(yacc_q);
			default: ;
		endcase

		if (emit) begin
			oy_q    <= take_walk ? yacc_q[YEAR_W-1:0] : ya_q;
			om_q    <= take_walk ? mm_q : ma_q;
			od_q    <= take_walk ? r_q[DAY_W-1:0] + 5'd1 : da_q;
			oless_q <= status.less_op && less_d;
			odiff_q <= status.diff_op ? diff_q : '0;
			ooor_q  <= status.diff_op ? dsat_q : (walk_op && !date_ok);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, ooor_q, odiff_q, oless_q, od_q, om_q, oy_q};

endmodule

`default_nettype wire

// ===== sv/gregorian_date_arithmetic.sv =====
`default_nettype none

// Gregorian date arithmetic unit. One beat in, one beat out. The opcode on
// s_tuser picks normalize A, A + day_count, A - day_count, A earlier than B,
// or |A - B| in days. Each date is checked first; a year of 0, a month
// outside 1..12 or a day past the end of its month reads as 1900-01-01.
// The day count is clamped to +/-DAY_COUNT_MAX. Dates go to a day number
// (0001-01-01 = 0) in the SER_P, SER_M and SER_SUM states, and back by a
// walk that strips 400-year, 100-year, 4-year and 1-year blocks and then
// months, one subtraction per cycle. A compare converts A and goes to EMIT;
// a difference converts A and then B, then goes through COMBINE to EMIT.
// EMIT waits while an untaken result sits in the output register. The
// 400-year block loop makes one pass per 400 years in the result. One item
// is worked at a time; the next beat is taken as soon as the result is parked
// in the output register, even if the sink has not taken it yet. A result
// whose year falls outside 1..YEAR_MAX (or below day 0) sets out_of_range
// and returns normalized A; a difference above 4194303 saturates and sets
// out_of_range. Opcodes 5 to 7 act as normalize. No state survives an item.

module gregorian_date_arithmetic #(
	parameter int YEAR_MAX      = gda_pkg::YEAR_MAX,
	parameter int DAY_COUNT_MAX = gda_pkg::DAY_COUNT_MAX
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// year_a[13:0] month_a[17:14] day_a[22:18] day_count[43:23]
	// year_b[57:44] month_b[61:58] day_b[66:62], zero pad above
	input  logic [gda_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode[2:0]
	input  logic [gda_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// res_year[13:0] res_month[17:14] res_day[22:18] is_less[23]
	// day_difference[45:24] out_of_range[46], zero pad above
	output logic [gda_pkg::M_TDATA_W-1:0]  m_tdata
);
	import gda_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: owns the phase and which date feeds the day-number unit
	gda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: validation, day-number unit, date walk, output register
	gda_dp #(
		.YEAR_MAX      (YEAR_MAX),
		.DAY_COUNT_MAX (DAY_COUNT_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	assign s_tready = cmd.ready;

	`include "gregorian_date_arithmetic_assert.svh"

	// an accepted beat drops s_tready in the cycle after
	`GDA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted twice in a row")
	// every result carries a real month
	`GDA_ASSERT_NOW(a_month_valid, m_tvalid, (m_tdata[17:14] >= 4'd1) && (m_tdata[17:14] <= 4'd12), "bad result month")
	// every result carries a nonzero day
	`GDA_ASSERT_NOW(a_day_nonzero, m_tvalid, m_tdata[22:18] != 5'd0, "zero result day")
	// a compare result never carries a difference or a range flag
	`GDA_ASSERT_NOW(a_less_alone, m_tvalid && m_tdata[23], (m_tdata[45:24] == 22'd0) && !m_tdata[46], "compare beat with difference")

endmodule

`default_nettype wire

// ===== dv/gregorian_date_arithmetic_test.sv =====
`default_nettype none

module gregorian_date_arithmetic_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gda_pkg::*;

	localparam int RESET_CYCLES     = 6;
	localparam int CYCLE_LIMIT      = 1_000_000;
	localparam int SETTLE_CYCLES    = 200;   // more than the longest date walk
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int PRESSURE_BEATS   = 40;
	localparam int RANDOM_BEATS     = 240;   // per idle phase

	// undefined opcodes run from just past OP_DIFF up to all ones
	localparam logic [OP_W-1:0] OP_LAST = '1;

	localparam longint DIFF_SAT = (longint'(1) << DIFF_W) - 1;

	// result beat layout, lowest bit up
	localparam int RM_LO    = YEAR_W;
	localparam int RD_LO    = RM_LO + MONTH_W;
	localparam int LESS_BIT = RD_LO + DAY_W;
	localparam int DIFF_LO  = LESS_BIT + 1;
	localparam int OOR_BIT  = DIFF_LO + DIFF_W;

	// request beat layout, lowest bit up
	localparam int MA_LO  = YEAR_W;
	localparam int DA_LO  = MA_LO + MONTH_W;
	localparam int CNT_LO = DA_LO + DAY_W;
	localparam int YB_LO  = CNT_LO + COUNT_W;
	localparam int MB_LO  = YB_LO + YEAR_W;
	localparam int DB_LO  = MB_LO + MONTH_W;

	typedef struct {
		logic [OP_W-1:0]           op;
		logic [YEAR_W-1:0]         ya;
		logic [MONTH_W-1:0]        ma;
		logic [DAY_W-1:0]          da;
		logic signed [COUNT_W-1:0] cnt;
		logic [YEAR_W-1:0]         yb;
		logic [MONTH_W-1:0]        mb;
		logic [DAY_W-1:0]          db;
	} date_req_t;

	typedef struct {
		longint year;
		longint month;
		longint day;
		longint less;
		longint diff;
		longint oor;
	} date_result_t;

	// ---------------------------------------------------------------
	// Calendar helpers (proleptic Gregorian)
	// ---------------------------------------------------------------
	function automatic bit leap_year(longint y);
		return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
	endfunction

	// 0 for a month outside 1..12, so any day fails against it
	function automatic longint month_len(longint y, longint m);
		case (m)
			2:                      return leap_year(y) ? 29 : 28;
			4, 6, 9, 11:            return 30;
			1, 3, 5, 7, 8, 10, 12:  return 31;
			default:                return 0;
		endcase
	endfunction

	function automatic bit date_ok(longint y, longint m, longint d);
		return y >= 1 && d >= 1 && d <= month_len(y, m);
	endfunction

	// day number, 0001-01-01 is day 0
	function automatic longint day_number(longint y, longint m, longint d);
		longint p;
		longint n;
		p = y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400;
		for (longint k = 1; k < m; k++)
			n += month_len(y, k);
		return n + d - 1;
	endfunction

	// inverse of day_number for n >= 0: estimate the year, then nudge it
	function automatic void date_of_day(longint n, output longint y, output longint m,
			output longint d);
		y = (n * 400) / 146097 + 1;
		while (day_number(y + 1, 1, 1) <= n) y++;
		while (day_number(y, 1, 1) > n) y--;
		n -= day_number(y, 1, 1);
		m = 1;
		while (n >= month_len(y, m)) begin
			n -= month_len(y, m);
			m++;
		end
		d = n + 1;
	endfunction

	// ---------------------------------------------------------------
	// Scoreboard: one expected result per accepted request, in order
	// ---------------------------------------------------------------
	class date_result_board;
		date_result_t outcomes_due[$];
		int           errors;

		function date_result_t calendar_outcome(date_req_t r);
			date_result_t res;
			longint ya, ma, da, yb, mb, db, c, sa, sb, n, y, m, d;
			ya = r.ya; ma = r.ma; da = r.da;
			yb = r.yb; mb = r.mb; db = r.db;
			// bad dates fall back to 1900-01-01
			if (!date_ok(ya, ma, da)) begin
				ya = 1900; ma = 1; da = 1;
			end
			if (!date_ok(yb, mb, db)) begin
				yb = 1900; mb = 1; db = 1;
			end
			c = r.cnt;
			if (c > DAY_COUNT_MAX) c = DAY_COUNT_MAX;
			if (c < -DAY_COUNT_MAX) c = -DAY_COUNT_MAX;

			res = '{year: ya, month: ma, day: da, less: 0, diff: 0, oor: 0};
			sa = day_number(ya, ma, da);
			if (r.op == OP_LESS) begin
				res.less = (ya < yb || (ya == yb && (ma < mb || (ma == mb && da < db))));
			end else if (r.op == OP_DIFF) begin
				sb = day_number(yb, mb, db);
				res.diff = sa > sb ? sa - sb : sb - sa;
				if (res.diff > DIFF_SAT) begin
					res.diff = DIFF_SAT;
					res.oor  = 1;
				end
			end else begin
				// normalize, add, subtract; undefined opcodes normalize
				n = sa;
				if (r.op == OP_ADD) n = sa + c;
				else if (r.op == OP_SUB) n = sa - c;
				if (n < 0) begin
					res.oor = 1;
				end else begin
					date_of_day(n, y, m, d);
					if (y > YEAR_MAX) res.oor = 1;
					else begin
						res.year = y; res.month = m; res.day = d;
					end
				end
			end
			return res;
		endfunction

		function void note_request(date_req_t r);
			outcomes_due.push_back(calendar_outcome(r));
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] beat);
			date_result_t want;
			if (outcomes_due.size() == 0) begin
				errors++;
				$display("%0t: result beat %h with none expected, expected nothing actual %h",
					$realtime, beat, beat);
				return;
			end
			want = outcomes_due.pop_front();
			compare_field("res_year", want.year, beat[0 +: YEAR_W]);
			compare_field("res_month", want.month, beat[RM_LO +: MONTH_W]);
			compare_field("res_day", want.day, beat[RD_LO +: DAY_W]);
			compare_field("is_less", want.less, beat[LESS_BIT]);
			compare_field("day_difference", want.diff, beat[DIFF_LO +: DIFF_W]);
			compare_field("out_of_range", want.oor, beat[OOR_BIT]);
		endfunction

		function int outstanding();
			return outcomes_due.size();
		endfunction
	endclass

	// ---------------------------------------------------------------
	// DUT and its stimulus signals, all known from time zero
	// ---------------------------------------------------------------
	logic                 clk;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	gregorian_date_arithmetic dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	date_result_board board = new();

	int src_idle = 17;     // percent of cycles the sender holds back
	int snk_idle = 54;     // percent of cycles the sink refuses
	bit sink_hold_req = 1'b0;
	int cycle_count = 0;

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Watchdog: a correct run ends far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Sink side. Ready moves on the falling edge. A hold request parks ready
	// low for a long stretch so the block backs up and drops s_tready.
	always begin
		@(negedge clk);
		if (sink_hold_req) begin
			sink_hold_req = 1'b0;
			m_tready <= 1'b0;
			repeat (SINK_HOLD_CYCLES) @(negedge clk);
		end
		m_tready <= ($urandom_range(99) >= snk_idle);
	end

	// Every result beat is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// ---------------------------------------------------------------
	// Request construction
	// ---------------------------------------------------------------
	function automatic date_req_t mk(logic [OP_W-1:0] op, int ya, int ma, int da, int cnt,
			int yb, int mb, int db);
		date_req_t r;
		r.op  = op;
		r.ya  = YEAR_W'(ya);
		r.ma  = MONTH_W'(ma);
		r.da  = DAY_W'(da);
		r.cnt = COUNT_W'(cnt);
		r.yb  = YEAR_W'(yb);
		r.mb  = MONTH_W'(mb);
		r.db  = DAY_W'(db);
		return r;
	endfunction

	// Mostly well-formed dates; now and then year 0, a bad month or a day
	// past the month end. Years reach past YEAR_MAX to the field top.
	function automatic void random_date(output int y, output int m, output int d);
		int len;
		case ($urandom_range(0, 9))
			0:       y = $urandom_range(0, 3);
			1:       y = $urandom_range(YEAR_MAX - 9, YEAR_MAX + 11);
			2:       y = $urandom_range(YEAR_MAX + 12, (1 << YEAR_W) - 1);
			3:       y = 100 * $urandom_range(1, 99);
			4:       y = $urandom_range(1, (1 << YEAR_W) - 1);
			default: y = $urandom_range(1580, 2500);
		endcase
		if ($urandom_range(0, 9) == 0)
			m = $urandom_range(0, 1) ? 0 : $urandom_range(13, (1 << MONTH_W) - 1);
		else
			m = $urandom_range(1, 12);
		len = int'(month_len(y, m));
		if ($urandom_range(0, 9) == 0 || len == 0)
			d = $urandom_range(0, (1 << DAY_W) - 1);
		else
			d = $urandom_range(1, len);
	endfunction

	function automatic date_req_t random_req();
		date_req_t r;
		int ya, ma, da, yb, mb, db, mag, pick;
		bit neg;
		pick = $urandom_range(0, 20);
		random_date(ya, ma, da);
		random_date(yb, mb, db);
		// compares and differences often look at nearby dates
		if ($urandom_range(0, 2) == 0) begin
			yb = ya;
			if ($urandom_range(0, 1)) mb = ma;
		end
		neg = $urandom_range(0, 1);
		case ($urandom_range(0, 4))
			0:       mag = $urandom_range(0, 3);
			1:       mag = $urandom_range(0, 400);
			2:       mag = $urandom_range(0, 40000);
			3:       mag = $urandom_range(0, DAY_COUNT_MAX);
			default: mag = $urandom_range(DAY_COUNT_MAX - 2, DAY_COUNT_MAX + 1);
		endcase
		r = mk(OP_NORM, ya, ma, da, neg ? -mag : mag, yb, mb, db);
		if (pick == 20)
			r.op = OP_W'($urandom_range(OP_DIFF + 1, OP_LAST));
		else
			r.op = OP_W'(pick % (OP_DIFF + 1));
		// raw bit patterns now and then, so every count bit toggles
		if ($urandom_range(0, 7) == 0)
			r.cnt = COUNT_W'($urandom);
		return r;
	endfunction

	// Offer one request, starting and ending on a falling edge. Random
	// sender gaps come first; the beat is noted when the handshake lands.
	task automatic send_req(date_req_t r);
		logic [S_TDATA_W-1:0] beat;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		beat = '0;
		beat[0 +: YEAR_W]       = r.ya;
		beat[MA_LO +: MONTH_W]  = r.ma;
		beat[DA_LO +: DAY_W]    = r.da;
		beat[CNT_LO +: COUNT_W] = r.cnt;
		beat[YB_LO +: YEAR_W]   = r.yb;
		beat[MB_LO +: MONTH_W]  = r.mb;
		beat[DB_LO +: DAY_W]    = r.db;
		s_tuser  <= r.op;
		s_tdata  <= beat;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_request(r);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// directed: range edges, leap rules, count sign and clamp, bad dates
		send_req(mk(OP_NORM, 1, 1, 1, 0, 0, 0, 0));
		send_req(mk(OP_NORM, YEAR_MAX, 12, 31, 0, 1, 1, 1));
		send_req(mk(OP_ADD, YEAR_MAX, 12, 31, 1, 1, 1, 1));        // past the top year
		send_req(mk(OP_SUB, 1, 1, 1, 1, 1, 1, 1));                 // before day zero
		send_req(mk(OP_ADD, 2000, 2, 28, 1, 1, 1, 1));             // 400-year leap
		send_req(mk(OP_ADD, 1900, 2, 28, 1, 1, 1, 1));             // century, no leap
		send_req(mk(OP_SUB, 2024, 3, 1, 1, 1, 1, 1));
		send_req(mk(OP_ADD, 2024, 1, 1, -1, 1, 1, 1));             // negative add
		send_req(mk(OP_SUB, 2023, 12, 31, -1, 1, 1, 1));           // negative subtract
		send_req(mk(OP_ADD, 1, 1, 1, DAY_COUNT_MAX, 1, 1, 1));
		send_req(mk(OP_ADD, YEAR_MAX, 12, 31, -(DAY_COUNT_MAX + 1), 1, 1, 1)); // clamp
		send_req(mk(OP_SUB, 1, 1, 1, -(DAY_COUNT_MAX + 1), 1, 1, 1));
		send_req(mk(OP_W'(OP_DIFF + 2), 0, 6, 15, 0, 1, 1, 1));   // year zero, odd opcode
		send_req(mk(OP_LAST, 2020, 13, 1, 0, 1, 1, 1));            // bad month
		send_req(mk(OP_ADD, 2020, 0, 1, 5, 1, 1, 1));
		send_req(mk(OP_NORM, 2021, 4, 31, 0, 1, 1, 1));            // day past month end
		send_req(mk(OP_NORM, 2023, 2, 29, 0, 1, 1, 1));
		send_req(mk(OP_NORM, 2024, 2, 29, 0, 1, 1, 1));
		send_req(mk(OP_W'(OP_DIFF + 1), (1 << YEAR_W) - 1, 12, 31, 0, 1, 1, 1));
		send_req(mk(OP_LESS, (1 << YEAR_W) - 1, 15, 31, 0, (1 << YEAR_W) - 1, 15, 31));
		send_req(mk(OP_LESS, 1999, 12, 31, 0, 2000, 1, 1));
		send_req(mk(OP_LESS, 2000, 5, 5, 0, 2000, 5, 5));
		send_req(mk(OP_LESS, 2000, 6, 1, 0, 2000, 5, 30));
		send_req(mk(OP_DIFF, 1, 1, 1, 0, YEAR_MAX, 12, 31));
		send_req(mk(OP_DIFF, (1 << YEAR_W) - 1, 12, 31, 0, 1, 1, 1)); // saturates

		// random: sender-light/sink-heavy, swapped, then no idling at all
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin src_idle = 17; snk_idle = 54; end
				1:       begin src_idle = 54; snk_idle = 17; end
				default: begin src_idle = 0;  snk_idle = 0;  end
			endcase
			if (phase == 2) begin
				// sink stalls while the sender keeps pushing, then drain fully
				sink_hold_req = 1'b1;
				repeat (PRESSURE_BEATS) send_req(random_req());
				s_tvalid <= 1'b0;
				@(negedge clk);
				while (board.outstanding() != 0) @(negedge clk);
			end
			repeat (RANDOM_BEATS) send_req(random_req());
		end
		s_tvalid <= 1'b0;

		while (board.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// ===== gregorian_date_arithmetic.f =====
+incdir+sv
sv/gda_pkg.sv
sv/gda_ctrl.sv
sv/gda_dp.sv
sv/gregorian_date_arithmetic.sv
dv/gregorian_date_arithmetic_test.sv
